// ===== hdl/rsq_pkg.sv =====
// Shared types and constants for the two-axis rectangle stepper sequencer.
package rsq_pkg;

  // Width of the tick counter and the step counter; the registers are taken modulo 2^CountWidth
  localparam int unsigned CountWidth = 16;

  // Configuration register widths and reset values
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgWidth-1:0] StepsXReset  = 16'd5000;
  localparam logic [CfgWidth-1:0] StepsYReset  = 16'd5000;
  localparam logic [CfgWidth-1:0] PeriodReset  = 16'd400;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_STEPS_X = 2'd0,
    REG_STEPS_Y = 2'd1,
    REG_PERIOD  = 2'd2
  } rsq_reg_e;

  // Rectangle legs
  typedef enum logic [1:0] {
    LEG_X_FWD = 2'd0,
    LEG_Y_FWD = 2'd1,
    LEG_X_BACK = 2'd2,
    LEG_Y_BACK = 2'd3
  } rsq_leg_e;

  // One result
  typedef struct packed {
    logic       x_step;
    logic       x_dir;
    logic       y_step;
    logic       y_dir;
    logic [1:0] leg;
    logic       halted;
  } rsq_result_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic       stopped;
    logic       step_high;
    logic [1:0] leg;
  } rsq_stat_t;

endpackage

// ===== hdl/rsq_core.sv =====
// Sequencer state, configuration registers and per-tick next-state logic.
module rsq_core import rsq_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [CfgWidth-1:0]        cfg_data_i,
  input  logic                       accept_i,
  input  logic                       x_limit_i,
  input  logic                       y_limit_i,
  output rsq_result_t                result_o,
  output rsq_stat_t                  stat_o
);

  logic [CfgWidth-1:0]   steps_x_q, steps_y_q, period_q;
  logic [CountWidth-1:0] tick_q, tick_d;
  logic [CountWidth-1:0] done_q, done_d;
  logic [1:0]            leg_q, leg_d;
  logic                  step_high_q, step_high_d;
  logic                  stopped_q, stopped_d;

  logic [CountWidth-1:0] period_w, len_w, done_inc;
  logic                  y_active, complete, limit_hit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_x_q <= StepsXReset;
      steps_y_q <= StepsYReset;
      period_q  <= PeriodReset;
    end else if (cfg_we_i) begin
      unique case (rsq_reg_e'(cfg_index_i))
        REG_STEPS_X: steps_x_q <= cfg_data_i;
        REG_STEPS_Y: steps_y_q <= cfg_data_i;
        REG_PERIOD:  period_q  <= cfg_data_i;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  assign y_active  = leg_q[0];
  assign period_w  = CountWidth'(period_q);
  assign len_w     = y_active ? CountWidth'(steps_y_q) : CountWidth'(steps_x_q);
  assign done_inc  = done_q + CountWidth'(1);
  assign complete  = (done_inc >= len_w);
  assign limit_hit = y_active ? y_limit_i : x_limit_i;

  // Next state for one tick
  always_comb begin
    tick_d      = tick_q;
    done_d      = done_q;
    leg_d       = leg_q;
    step_high_d = step_high_q;
    stopped_d   = stopped_q;
    if (!stopped_q) begin
      if (tick_q >= period_w) begin
        tick_d = '0;
        if (!step_high_q) begin
          step_high_d = 1'b1;
        end else begin
          // falling half: count a step, check limit, then leg end
          step_high_d = 1'b0;
          done_d      = complete ? '0 : done_inc;
          if (limit_hit) begin
            done_d    = '0;
            stopped_d = 1'b1;
          end else if (complete) begin
            leg_d = leg_q + 2'd1;
          end
        end
      end else begin
        tick_d = tick_q + CountWidth'(1);
      end
    end
  end

  // State registers advance once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      done_q      <= '0;
      leg_q       <= LEG_X_FWD;
      step_high_q <= 1'b0;
      stopped_q   <= 1'b0;
    end else if (accept_i) begin
      tick_q      <= tick_d;
      done_q      <= done_d;
      leg_q       <= leg_d;
      step_high_q <= step_high_d;
      stopped_q   <= stopped_d;
    end
  end

  // Result from the updated state
  always_comb begin
    result_o.x_step = ~leg_d[0] & step_high_d;
    result_o.y_step = leg_d[0] & step_high_d;
    result_o.x_dir  = (leg_d == LEG_X_FWD) || (leg_d == LEG_Y_FWD);
    result_o.y_dir  = (leg_d == LEG_Y_FWD) || (leg_d == LEG_X_BACK);
    result_o.leg    = leg_d;
    result_o.halted = stopped_d;
  end

  assign stat_o = '{stopped: stopped_q, step_high: step_high_q, leg: leg_q};

endmodule

// ===== hdl/rsq_skid.sv =====
// Two-entry result buffer that decouples input acceptance from output stall.
module rsq_skid import rsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rsq_result_t data_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        stall_i,
  output rsq_result_t data_o
);

  rsq_result_t head_q, tail_q;
  logic        head_vld_q, tail_vld_q;
  logic        pop;

  assign pop     = head_vld_q & ~stall_i;
  assign valid_o = head_vld_q;
  assign full_o  = tail_vld_q;
  assign data_o  = head_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      case ({push_i, pop})
        2'b11: ;
        2'b10: begin
          if (head_vld_q) tail_vld_q <= 1'b1;
          else            head_vld_q <= 1'b1;
        end
        2'b01: begin
          if (tail_vld_q) tail_vld_q <= 1'b0;
          else            head_vld_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      head_q <= tail_vld_q ? tail_q : data_i;
      if (push_i && tail_vld_q) tail_q <= data_i;
    end else if (push_i) begin
      if (head_vld_q) tail_q <= data_i;
      else            head_q <= data_i;
    end
  end

endmodule

// ===== hdl/two_axis_rectangle_stepper_sequencer.sv =====
// Top level of the two-axis rectangle stepper sequencer.
// A tick request's result is registered in the result buffer before it reaches the output.
// Throughput: one tick request per cycle when not stalled; a single compare-and-increment.
// A two-entry result buffer; in_stall_o rises only once both entries hold waiting results.
// Reset (rst_ni low, asynchronous) loads default registers, leg X forward, counters zero.
module two_axis_rectangle_stepper_sequencer import rsq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   x_limit_i,
  input  logic                   y_limit_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   x_step_o,
  output logic                   x_dir_o,
  output logic                   y_step_o,
  output logic                   y_dir_o,
  output logic [1:0]             leg_o,
  output logic                   halted_o
);

  logic        accept;
  logic        full;
  rsq_result_t result;
  rsq_result_t out_data;
  rsq_stat_t   stat;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  rsq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .x_limit_i   (x_limit_i),
    .y_limit_i   (y_limit_i),
    .result_o    (result),
    .stat_o      (stat)
  );

  rsq_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data)
  );

  assign x_step_o = out_data.x_step;
  assign x_dir_o  = out_data.x_dir;
  assign y_step_o = out_data.y_step;
  assign y_dir_o  = out_data.y_dir;
  assign leg_o    = out_data.leg;
  assign halted_o = out_data.halted;

  // Halt lasts until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.stopped |=> stat.stopped)
    else $error("halt released without reset");

  // A halted block holds its step line low
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.stopped |-> !stat.step_high)
    else $error("step line high while halted");

  // Legs only advance on a falling half
  a_leg_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.leg != $past(stat.leg)) |-> ($past(stat.step_high) && !stat.step_high))
    else $error("leg changed without a falling step half");

endmodule

// ===== dv/two_axis_rectangle_stepper_sequencer_tb.sv =====
// Self-checking testbench for the two-axis rectangle stepper sequencer.
module two_axis_rectangle_stepper_sequencer_tb;
  import rsq_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int ItemTarget    = 1520;
  localparam int DrainCycles   = 8;
  localparam int IdlePercent   = 31;
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;

  // One tick request: sampled limit switches
  typedef struct packed {
    logic x_lim;
    logic y_lim;
  } tick_t;

  // Motion state of the sequencer
  typedef struct {
    logic [CountWidth-1:0] ticks;
    logic                  step_hi;
    logic [CountWidth-1:0] steps;
    rsq_leg_e              leg;
    logic                  stopped;
  } mech_t;

  typedef struct {
    logic [CfgWidth-1:0] len_x;
    logic [CfgWidth-1:0] len_y;
    logic [CfgWidth-1:0] period;
  } cfg_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CfgWidth-1:0]    cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   x_limit_i = 1'b0;
  logic                   y_limit_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   x_step_o;
  logic                   x_dir_o;
  logic                   y_step_o;
  logic                   y_dir_o;
  logic [1:0]             leg_o;
  logic                   halted_o;

  two_axis_rectangle_stepper_sequencer dut (.*);

  tick_t       tick_q[$];
  rsq_result_t motion_q[$];
  cfg_t        cfg_live;
  mech_t       pred_st;   // advanced on each accepted request
  mech_t       plan_st;   // advanced as requests are queued
  bit          calm = 1'b0;
  int          errors = 0;
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // One timer tick of the sequencer; returns the line levels after it
  function automatic rsq_result_t advance_tick(inout mech_t m, input logic xl, input logic yl);
    rsq_result_t r;
    logic [CountWidth-1:0] len;
    logic done;
    logic y_act;
    y_act = m.leg[0];
    if (!m.stopped) begin
      if (m.ticks >= CountWidth'(cfg_live.period)) begin
        m.ticks = '0;
        if (!m.step_hi) begin
          m.step_hi = 1'b1;
        end else begin
          // falling half: count a step, then check limit and leg end
          m.step_hi = 1'b0;
          len = y_act ? CountWidth'(cfg_live.len_y) : CountWidth'(cfg_live.len_x);
          m.steps = m.steps + CountWidth'(1);
          done = (m.steps >= len);
          if (done) m.steps = '0;
          if (y_act ? yl : xl) begin
            m.steps = '0;
            m.stopped = 1'b1;
          end else if (done) begin
            m.leg = m.leg.next();
          end
        end
      end else begin
        m.ticks = m.ticks + CountWidth'(1);
      end
    end
    y_act = m.leg[0];
    r.x_step = !y_act && m.step_hi;
    r.x_dir  = (m.leg == LEG_X_FWD) || (m.leg == LEG_Y_FWD);
    r.y_step = y_act && m.step_hi;
    r.y_dir  = (m.leg == LEG_Y_FWD) || (m.leg == LEG_X_BACK);
    r.leg    = m.leg;
    r.halted = m.stopped;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (errors < 30) $display("MISMATCH at result %0d: %s", n_results, msg);
    errors++;
  endtask

  // Register write; drives the write strobe, then updates the bench's copy of the settings
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_STEPS_X) cfg_live.len_x = val;
    else if (idx == REG_STEPS_Y) cfg_live.len_y = val;
    else if (idx == REG_PERIOD) cfg_live.period = val;
  endtask

  // Queue requests; the active axis limit stays clear on a falling half
  // unless a halt is wanted, then the phase runs on past the halt
  task automatic queue_ticks(input int count, input bit halt);
    tick_t t;
    int    left;
    logic  fall;
    logic  hit;
    left = count;
    @(negedge clk_i);
    while (left > 0) begin
      t.x_lim = 1'($urandom_range(0, 1));
      t.y_lim = 1'($urandom_range(0, 1));
      fall = !plan_st.stopped && plan_st.step_hi &&
             (plan_st.ticks >= CountWidth'(cfg_live.period));
      if (fall) begin
        hit = halt && ($urandom_range(0, 1) == 1);
        if (plan_st.leg[0]) t.y_lim = hit;
        else t.x_lim = hit;
      end
      void'(advance_tick(plan_st, t.x_lim, t.y_lim));
      tick_q.push_back(t);
      n_queued++;
      if (!halt || plan_st.stopped) left--;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || motion_q.size() != 0);
  endtask

  // Mostly short values, sometimes the extremes or anything
  function automatic logic [CfgWidth-1:0] pick_count(input int short_max);
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return CfgWidth'($urandom_range(0, short_max));
    if (p < 80) return '0;
    if (p < 85) return '1;
    return CfgWidth'($urandom_range(0, 65535));
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_ticks
    tick_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      x_limit_i  <= 1'b0;
      y_limit_i  <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        motion_q.push_back(advance_tick(pred_st, x_limit_i, y_limit_i));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePercent)) begin
          nxt = tick_q.pop_front();
          in_valid_i <= 1'b1;
          x_limit_i  <= nxt.x_lim;
          y_limit_i  <= nxt.y_lim;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin : check_motion
    rsq_result_t want;
    rsq_result_t got;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {x_step_o, x_dir_o, y_step_o, y_dir_o, leg_o, halted_o};
        n_results++;
        if (motion_q.size() == 0) begin
          flag_mismatch("result with nothing expected");
        end else begin
          want = motion_q.pop_front();
          if (got.x_step !== want.x_step)
            flag_mismatch($sformatf("x_step %b, expected %b", got.x_step, want.x_step));
          if (got.x_dir !== want.x_dir)
            flag_mismatch($sformatf("x_dir %b, expected %b", got.x_dir, want.x_dir));
          if (got.y_step !== want.y_step)
            flag_mismatch($sformatf("y_step %b, expected %b", got.y_step, want.y_step));
          if (got.y_dir !== want.y_dir)
            flag_mismatch($sformatf("y_dir %b, expected %b", got.y_dir, want.y_dir));
          if (got.leg !== want.leg)
            flag_mismatch($sformatf("leg %0d, expected %0d", got.leg, want.leg));
          if (got.halted !== want.halted)
            flag_mismatch($sformatf("halted %b, expected %b", got.halted, want.halted));
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePercent);
    end
  end

  // Cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("Timeout: nothing moved for %0d cycles", WatchdogLimit);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase;
    cfg_live = '{len_x: StepsXReset, len_y: StepsYReset, period: PeriodReset};
    pred_st  = '{ticks: '0, step_hi: 1'b0, steps: '0, leg: LEG_X_FWD, stopped: 1'b0};
    plan_st  = pred_st;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults: counter only runs, limits are free
    queue_ticks(4, 1'b0);
    wait_drained();
    // Zero-length X leg, one-step Y leg, fastest period, bad index ignored
    write_reg(REG_STEPS_X, '0);
    write_reg(REG_STEPS_Y, 16'd1);
    write_reg(REG_PERIOD, '0);
    write_reg(RegUnused, '1);
    queue_ticks(12, 1'b0);
    wait_drained();
    // Largest settings
    write_reg(REG_STEPS_X, '1);
    write_reg(REG_STEPS_Y, '1);
    write_reg(REG_PERIOD, '1);
    queue_ticks(3, 1'b0);
    wait_drained();
    // Let the counter climb, then drop the period below it
    write_reg(REG_PERIOD, 16'd6);
    queue_ticks(3, 1'b0);
    wait_drained();
    write_reg(REG_PERIOD, 16'd2);
    queue_ticks(3, 1'b0);
    wait_drained();

    // Random setting phases
    phase = 0;
    while (n_queued < ItemTarget) begin
      if ($urandom_range(0, 3) != 0) write_reg(REG_STEPS_X, pick_count(6));
      if ($urandom_range(0, 3) != 0) write_reg(REG_STEPS_Y, pick_count(6));
      if ($urandom_range(0, 3) != 0) write_reg(REG_PERIOD, pick_count(3));
      if ($urandom_range(0, 6) == 0) write_reg(RegUnused, CfgWidth'($urandom_range(0, 65535)));
      calm = (phase == 3);
      queue_ticks(calm ? 250 : $urandom_range(20, 120), 1'b0);
      wait_drained();
      phase++;
    end
    calm = 1'b0;

    // Trip a limit switch on the active axis, then keep ticking while halted
    write_reg(REG_STEPS_X, CfgWidth'($urandom_range(0, 4)));
    write_reg(REG_STEPS_Y, CfgWidth'($urandom_range(0, 4)));
    write_reg(REG_PERIOD, CfgWidth'($urandom_range(0, 2)));
    queue_ticks(30, 1'b1);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (motion_q.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", motion_q.size()));
    $display("Ran %0d tick requests over %0d random setting phases; %0d results checked.",
             n_accepted, phase, n_results);
    $display("Sequencer ended in leg %s, %s.", pred_st.leg.name(),
             pred_st.stopped ? "halted by a limit switch" : "still running");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
